>>> sv/pbdt_pkg.sv
`timescale 1ns / 1ps

package pbdt_pkg;

  // Default sizing
  localparam int MAX_BYTES_DEF = 16;
  localparam int MAX_SCALE     = 31;

  // Fixed field widths
  localparam int BYTE_W  = 8;
  localparam int SCALE_W = 5;
  localparam int CNT_W   = 5;
  localparam int STAT_W  = 2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_DIGIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_SIGN  = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd3;

  // Sign nibbles
  localparam logic [3:0] SIGN_A = 4'hA;
  localparam logic [3:0] SIGN_B = 4'hB;
  localparam logic [3:0] SIGN_C = 4'hC;
  localparam logic [3:0] SIGN_D = 4'hD;
  localparam logic [3:0] SIGN_E = 4'hE;
  localparam logic [3:0] SIGN_F = 4'hF;

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  // ASCII characters
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_NONE  = 8'h00;

  // One complete number handed from the front to the back
  typedef struct packed {
    logic               bank;
    logic [CNT_W-1:0]   count;
    logic               ovf;
    logic [SCALE_W-1:0] scale;
  } desc_t;

endpackage

>>> sv/pbdt_ram.sv
`timescale 1ns / 1ps

module pbdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/pbdt_front.sv
`timescale 1ns / 1ps

module pbdt_front #(
  parameter int MAX_BYTES = pbdt_pkg::MAX_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          q_full,
  input  logic [pbdt_pkg::BYTE_W-1:0]   packed_byte,
  input  logic [pbdt_pkg::SCALE_W-1:0]  frac_digits,
  input  logic                          last_byte,
  output logic                          busy,
  output logic                          ram_we,
  output logic [((MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1):0] ram_waddr,
  output logic [pbdt_pkg::BYTE_W-1:0]   ram_wdata,
  output logic                          q_push,
  output pbdt_pkg::desc_t               q_desc
);

  import pbdt_pkg::*;

  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  logic             bank;
  logic [CNT_W-1:0] count;
  logic             ovf;
  logic             accept;
  logic             room;

  assign busy   = q_full;
  assign accept = start && !busy;
  assign room   = (count < CNT_W'(MAX_BYTES));

  // Store the byte into the bank of the number being loaded
  assign ram_we    = accept && room;
  assign ram_waddr = {bank, count[IDX_W-1:0]};
  assign ram_wdata = packed_byte;

  // Last byte closes the number and hands it to the back
  assign q_push       = accept && last_byte;
  assign q_desc.bank  = bank;
  assign q_desc.count = room ? count + CNT_W'(1) : count;
  assign q_desc.ovf   = ovf || !room;
  assign q_desc.scale = (frac_digits > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : frac_digits;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank  <= 1'b0;
      count <= '0;
      ovf   <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        bank  <= !bank;
        count <= '0;
        ovf   <= 1'b0;
      end else if (room) begin
        count <= count + CNT_W'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

endmodule

>>> sv/pbdt_queue.sv
`timescale 1ns / 1ps

module pbdt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pbdt_pkg::desc_t push_desc,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output pbdt_pkg::desc_t head
);

  import pbdt_pkg::*;

  desc_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = slots[rd_ptr];

  // Two-entry request queue; the head stays until the back finishes it
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> sv/pbdt_back.sv
`timescale 1ns / 1ps

module pbdt_back #(
  parameter int MAX_BYTES = pbdt_pkg::MAX_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_not_empty,
  input  pbdt_pkg::desc_t              head,
  output logic                         pop,
  output logic [((MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1):0] ram_raddr,
  input  logic [pbdt_pkg::BYTE_W-1:0]  ram_rdata,
  output logic                         strobe,
  output logic [pbdt_pkg::BYTE_W-1:0]  text_char,
  output logic [pbdt_pkg::STAT_W-1:0]  status,
  output logic                         last_char
);

  import pbdt_pkg::*;

  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int NIB_W = IDX_W + 1;
  localparam int WW    = (NIB_W > SCALE_W) ? NIB_W : SCALE_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CHK = 4'd2;
  localparam logic [3:0] S_FIN      = 4'd3;
  localparam logic [3:0] S_PLAN     = 4'd4;
  localparam logic [3:0] S_ERR      = 4'd5;
  localparam logic [3:0] S_MINUS    = 4'd6;
  localparam logic [3:0] S_ZERO     = 4'd7;
  localparam logic [3:0] S_DOT      = 4'd8;
  localparam logic [3:0] S_PAD      = 4'd9;
  localparam logic [3:0] S_DIG_RD   = 4'd10;
  localparam logic [3:0] S_DIG_EMIT = 4'd11;

  logic [3:0]        state;
  logic [WW-1:0]     p;
  logic [WW-1:0]     lead;
  logic [WW-1:0]     lastnz;
  logic [WW-1:0]     tail;
  logic [WW-1:0]     scl;
  logic [WW-1:0]     dot_at;
  logic [WW-1:0]     pad;
  logic              found;
  logic              bad;
  logic              neg;
  logic              zpfx;
  logic              dot_pend;
  logic [3:0]        sign;
  logic [STAT_W-1:0] err;

  logic [WW-1:0] cnt_w;
  logic [WW-1:0] hi_i;
  logic [WW-1:0] lo_i;
  logic [3:0]    hi;
  logic [3:0]    lo;
  logic          lastb;
  logic [WW-1:0] ndig;
  logic [WW-1:0] tz;
  logic [WW-1:0] drop;
  logic [WW-1:0] nd;
  logic [3:0]    dnib;
  logic          sign_pos;
  logic          sign_neg;
  logic          dig_last;

  // Scan and digit decode helpers
  always_comb begin
    cnt_w    = WW'(head.count);
    hi       = ram_rdata[7:4];
    lo       = ram_rdata[3:0];
    hi_i     = WW'({p, 1'b0});
    lo_i     = hi_i + WW'(1);
    lastb    = (p == cnt_w - WW'(1));
    ndig     = WW'({cnt_w, 1'b0}) - WW'(1);
    tz       = ndig - WW'(1) - lastnz;
    drop     = (scl < tz) ? scl : tz;
    nd       = tail - lead;
    dnib     = p[0] ? ram_rdata[3:0] : ram_rdata[7:4];
    sign_pos = (sign == SIGN_A) || (sign == SIGN_C) || (sign == SIGN_E) || (sign == SIGN_F);
    sign_neg = (sign == SIGN_B) || (sign == SIGN_D);
    dig_last = (p == tail - WW'(1));
  end

  // Byte address during scan, nibble pair address during emission
  assign ram_raddr = (state == S_SCAN_RD) ? {head.bank, p[IDX_W-1:0]}
                                          : {head.bank, p[IDX_W:1]};

  // Request is done on its final result
  assign pop = (state == S_ERR) || ((state == S_DIG_EMIT) && dig_last);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (state == S_ERR) || (state == S_MINUS) || (state == S_ZERO) ||
                (state == S_DOT) || (state == S_PAD) || (state == S_DIG_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_ERR: begin
        text_char <= CH_NONE;
        status    <= err;
        last_char <= 1'b1;
      end
      S_MINUS: begin
        text_char <= CH_MINUS;
        status    <= ST_OK;
        last_char <= 1'b0;
      end
      S_DOT: begin
        text_char <= CH_DOT;
        status    <= ST_OK;
        last_char <= 1'b0;
      end
      S_ZERO: begin
        text_char <= CH_ZERO;
        status    <= ST_OK;
        last_char <= 1'b0;
      end
      S_PAD: begin
        text_char <= CH_ZERO;
        status    <= ST_OK;
        last_char <= 1'b0;
      end
      S_DIG_EMIT: begin
        text_char <= CH_ZERO + BYTE_W'(dnib);
        status    <= ST_OK;
        last_char <= dig_last;
      end
      default: begin
        text_char <= CH_NONE;
        status    <= ST_OK;
        last_char <= 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          p     <= '0;
          found <= 1'b0;
          bad   <= 1'b0;
          scl   <= WW'(head.scale);
          if (q_not_empty) begin
            if (head.ovf) begin
              err   <= ST_OVERFLOW;
              state <= S_ERR;
            end else if (head.count == '0) begin
              err   <= ST_BAD_DIGIT;
              state <= S_ERR;
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if ((hi > DIGIT_MAX) || (!lastb && (lo > DIGIT_MAX))) begin
            bad <= 1'b1;
          end
          if (!found) begin
            if (hi != 4'd0) begin
              lead  <= hi_i;
              found <= 1'b1;
            end else if (!lastb && (lo != 4'd0)) begin
              lead  <= lo_i;
              found <= 1'b1;
            end
          end
          if (!lastb && (lo != 4'd0)) begin
            lastnz <= lo_i;
          end else if (hi != 4'd0) begin
            lastnz <= hi_i;
          end
          if (lastb) begin
            sign  <= lo;
            state <= S_FIN;
          end else begin
            p     <= p + WW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_FIN: begin
          if (!(sign_pos || sign_neg)) begin
            err   <= ST_BAD_SIGN;
            state <= S_ERR;
          end else if (bad) begin
            err   <= ST_BAD_DIGIT;
            state <= S_ERR;
          end else if (!found) begin
            // all-zero value prints as a single positive zero
            lead  <= '0;
            tail  <= WW'(1);
            scl   <= '0;
            neg   <= 1'b0;
            state <= S_PLAN;
          end else begin
            tail  <= ndig - drop;
            scl   <= scl - drop;
            neg   <= sign_neg;
            state <= S_PLAN;
          end
        end
        S_PLAN: begin
          p        <= lead;
          zpfx     <= (scl != '0) && (nd <= scl);
          dot_pend <= (scl != '0) && (nd > scl);
          dot_at   <= tail - scl;
          pad      <= scl - nd;
          if (neg) begin
            state <= S_MINUS;
          end else if ((scl != '0) && (nd <= scl)) begin
            state <= S_ZERO;
          end else begin
            state <= S_DIG_RD;
          end
        end
        S_MINUS: state <= zpfx ? S_ZERO : S_DIG_RD;
        S_ZERO:  state <= S_DOT;
        S_DOT: begin
          dot_pend <= 1'b0;
          state    <= (zpfx && (pad != '0)) ? S_PAD : S_DIG_RD;
        end
        S_PAD: begin
          pad <= pad - WW'(1);
          if (pad == WW'(1)) begin
            state <= S_DIG_RD;
          end
        end
        S_DIG_RD: state <= S_DIG_EMIT;
        S_DIG_EMIT: begin
          p <= p + WW'(1);
          if (dig_last) begin
            state <= S_IDLE;
          end else if (dot_pend && ((p + WW'(1)) == dot_at)) begin
            state <= S_DOT;
          end else begin
            state <= S_DIG_RD;
          end
        end
        S_ERR:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/packed_bcd_to_decimal_text.sv
`timescale 1ns / 1ps

// Packed-decimal to ASCII text. Bytes of a number are taken one per cycle
// (start high, busy low), high nibble first, the last one carrying the sign
// nibble. The front stores bytes into one of two RAM banks and, on the last
// byte, queues the number; the back picks the number up, then scans the
// stored bytes (one RAM read per byte), trims it in the S_FIN and S_PLAN
// states, and emits the text one sign, point or padding character or digit
// at a time (one RAM read per digit).
// A bad number gives a single result with a nonzero status. Results appear on
// text_char/status/last_char for exactly one cycle, marked by strobe; there
// is no way to hold them off. The two-entry queue lets the next number load
// while the previous one is still being emitted; busy is high while the queue
// holds two finished numbers, the one being emitted included.
module packed_bcd_to_decimal_text #(
  parameter int MAX_BYTES = pbdt_pkg::MAX_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [pbdt_pkg::BYTE_W-1:0]   packed_byte,
  input  logic [pbdt_pkg::SCALE_W-1:0]  frac_digits,
  input  logic                          last_byte,
  output logic                          strobe,
  output logic [pbdt_pkg::BYTE_W-1:0]   text_char,
  output logic [pbdt_pkg::STAT_W-1:0]   status,
  output logic                          last_char
);

  import pbdt_pkg::*;

  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int AW    = IDX_W + 1;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_not_empty;
  desc_t             q_in;
  desc_t             q_head;

  pbdt_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (1 << AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pbdt_front #(
    .MAX_BYTES (MAX_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .q_full      (q_full),
    .packed_byte (packed_byte),
    .frac_digits (frac_digits),
    .last_byte   (last_byte),
    .busy        (busy),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .q_push      (q_push),
    .q_desc      (q_in)
  );

  pbdt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  pbdt_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .head        (q_head),
    .pop         (q_pop),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .strobe      (strobe),
    .text_char   (text_char),
    .status      (status),
    .last_char   (last_char)
  );

endmodule

>>> sim/tb_packed_bcd_to_decimal_text.sv
`timescale 1ns / 1ps

import pbdt_pkg::*;

// Tracks converter state and the characters each number should produce.
class decimal_text_board;
  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic [STAT_W-1:0] st;
    logic              fin;
  } text_result_t;

  text_result_t      expected_text[$];
  logic [BYTE_W-1:0] held[MAX_BYTES_DEF];
  int unsigned       held_n;
  bit                spilled;
  int                errors;

  function void report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endfunction

  // Nibble i of the held number, high nibble of each byte first
  function logic [3:0] digit(int unsigned i);
    logic [BYTE_W-1:0] b;
    b = held[i >> 1];
    return (i & 1) ? b[3:0] : b[7:4];
  endfunction

  function void push_char(logic [BYTE_W-1:0] ch);
    expected_text.push_back('{ch, ST_OK, 1'b0});
  endfunction

  function void push_error(logic [STAT_W-1:0] code);
    expected_text.push_back('{CH_NONE, code, 1'b1});
  endfunction

  // Accepted request: store the byte; on the last byte, work out the text
  function void note_byte(logic [BYTE_W-1:0] b, logic [SCALE_W-1:0] f, logic l);
    int unsigned  n, ndig, lead, tail, nd, sc, ip, i;
    logic [3:0]   sgn;
    bit           neg, ovf;
    text_result_t tail_res;
    if (held_n < MAX_BYTES_DEF) begin
      held[held_n] = b;
      held_n++;
    end else begin
      spilled = 1'b1;
    end
    if (!l) return;
    n = held_n;
    ovf = spilled;
    held_n = 0;
    spilled = 1'b0;
    if (ovf) begin
      push_error(ST_OVERFLOW);
      return;
    end
    sc = (f > MAX_SCALE) ? MAX_SCALE : f;

    // Sign first, then every digit nibble
    sgn = held[n-1][3:0];
    if (sgn == SIGN_A || sgn == SIGN_C || sgn == SIGN_E || sgn == SIGN_F) begin
      neg = 1'b0;
    end else if (sgn == SIGN_B || sgn == SIGN_D) begin
      neg = 1'b1;
    end else begin
      push_error(ST_BAD_SIGN);
      return;
    end
    ndig = 2 * n - 1;
    for (i = 0; i < ndig; i++) begin
      if (digit(i) > DIGIT_MAX) begin
        push_error(ST_BAD_DIGIT);
        return;
      end
    end

    // Trim leading zeros, then trailing fraction zeros
    lead = 0;
    tail = ndig;
    while (lead < ndig && digit(lead) == 0) lead++;
    if (lead == ndig) begin
      lead = 0;
      tail = 1;
      sc = 0;
      neg = 1'b0;
    end else begin
      while (sc > 0 && tail > lead + 1 && digit(tail - 1) == 0) begin
        tail--;
        sc--;
      end
    end
    nd = tail - lead;

    // Text
    if (neg) push_char(CH_MINUS);
    if (sc == 0) begin
      for (i = 0; i < nd; i++) push_char(CH_ZERO + digit(lead + i));
    end else if (nd > sc) begin
      ip = nd - sc;
      for (i = 0; i < ip; i++) push_char(CH_ZERO + digit(lead + i));
      push_char(CH_DOT);
      for (i = ip; i < nd; i++) push_char(CH_ZERO + digit(lead + i));
    end else begin
      push_char(CH_ZERO);
      push_char(CH_DOT);
      for (i = 0; i < sc - nd; i++) push_char(CH_ZERO);
      for (i = 0; i < nd; i++) push_char(CH_ZERO + digit(lead + i));
    end
    tail_res = expected_text.pop_back();
    tail_res.fin = 1'b1;
    expected_text.push_back(tail_res);
  endfunction

  // Compare one strobed character with the oldest expectation
  function void check_text(logic [BYTE_W-1:0] ch, logic [STAT_W-1:0] st, logic fin);
    text_result_t want;
    if (expected_text.size() == 0) begin
      report($sformatf("result %h status %0d with nothing pending", ch, st));
      return;
    end
    want = expected_text.pop_front();
    if (ch !== want.ch)
      report($sformatf("text_char %h, wanted %h", ch, want.ch));
    if (st !== want.st)
      report($sformatf("status %0d, wanted %0d", st, want.st));
    if (fin !== want.fin)
      report($sformatf("last_char %b, wanted %b (char %h)", fin, want.fin, want.ch));
  endfunction
endclass

module tb_packed_bcd_to_decimal_text;
  localparam int QUIET_LIMIT = 3000;
  localparam int BYTE_TARGET = 200;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [BYTE_W-1:0]  packed_byte = '0;
  logic [SCALE_W-1:0] frac_digits = '0;
  logic               last_byte = 1'b0;
  logic               busy;
  logic               strobe;
  logic [BYTE_W-1:0]  text_char;
  logic [STAT_W-1:0]  status;
  logic               last_char;

  decimal_text_board board;
  logic [BYTE_W-1:0] number_bytes[$];
  int                idle_pct = 0;
  int                sent_bytes = 0;
  int                quiet_cycles = 0;

  always #2 clk = ~clk;

  packed_bcd_to_decimal_text dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .packed_byte(packed_byte),
    .frac_digits(frac_digits),
    .last_byte(last_byte),
    .strobe(strobe),
    .text_char(text_char),
    .status(status),
    .last_char(last_char)
  );

  // Result monitor
  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) board.check_text(text_char, status, last_char);
  end

  // Watchdog: cycles with neither a request nor a result accepted
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_packed_bcd_to_decimal_text NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request; held until busy is low at an edge, then maybe a gap
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [SCALE_W-1:0] f,
                           input logic l);
    start <= 1'b1;
    packed_byte <= b;
    frac_digits <= f;
    last_byte <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_byte(b, f, l);
    sent_bytes++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Send number_bytes; scale rides on the last byte, noise on the others
  task automatic send_number(input logic [SCALE_W-1:0] scale);
    int i;
    for (i = 0; i < number_bytes.size(); i++) begin
      if (i == number_bytes.size() - 1)
        send_byte(number_bytes[i], scale, 1'b1);
      else
        send_byte(number_bytes[i], SCALE_W'($urandom_range(31)), 1'b0);
    end
  endtask

  // kind 0: widest negative number at full scale; kind 1: overflow; else random
  task automatic send_random_number(input int kind);
    logic [3:0]         nibs[40];
    logic [3:0]         valid_signs[6];
    logic [SCALE_W-1:0] sc;
    int                 nb, nn, i, r, zlead, ztail;
    valid_signs = '{SIGN_A, SIGN_B, SIGN_C, SIGN_D, SIGN_E, SIGN_F};
    r = $urandom_range(99);
    if (kind == 0) nb = MAX_BYTES_DEF;
    else if (kind == 1) nb = MAX_BYTES_DEF + 1;
    else if (r < 70) nb = $urandom_range(1, 4);
    else if (r < 94) nb = $urandom_range(5, MAX_BYTES_DEF);
    else nb = $urandom_range(MAX_BYTES_DEF + 1, MAX_BYTES_DEF + 3);
    nn = 2 * nb;

    // Digits, with runs of leading and trailing zeros
    for (i = 0; i < nn; i++)
      nibs[i] = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(9));
    zlead = ($urandom_range(3) == 0) ? $urandom_range(nn - 1) : 0;
    for (i = 0; i < zlead; i++) nibs[i] = 4'd0;
    ztail = ($urandom_range(2) == 0) ? $urandom_range(nn - 1) : 0;
    for (i = 0; i < ztail; i++) nibs[nn - 2 - i] = 4'd0;
    if ($urandom_range(11) == 0)
      for (i = 0; i < nn - 1; i++) nibs[i] = 4'd0;
    if ($urandom_range(15) == 0) nibs[$urandom_range(nn - 2)] = 4'($urandom_range(10, 15));

    // Sign nibble, occasionally broken
    if ($urandom_range(99) < 8) nibs[nn - 1] = 4'($urandom_range(9));
    else nibs[nn - 1] = valid_signs[$urandom_range(5)];

    if ($urandom_range(1)) sc = SCALE_W'($urandom_range((nn - 1 > 31) ? 31 : nn - 1));
    else sc = SCALE_W'($urandom_range(31));

    if (kind == 0) begin
      for (i = 0; i < nn - 1; i++) nibs[i] = 4'($urandom_range(1, 9));
      nibs[nn - 1] = SIGN_D;
      sc = SCALE_W'(MAX_SCALE);
    end

    number_bytes.delete();
    for (i = 0; i < nb; i++) number_bytes.push_back({nibs[2 * i], nibs[2 * i + 1]});
    send_number(sc);
  endtask

  initial begin
    int num_idx;
    int phase_idle[4];
    phase_idle = '{0, 67, 0, 11};
    board = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero values, signs, padding, trimming, error precedence
    number_bytes = '{8'h0C};         send_number(5'd0);
    number_bytes = '{8'h0B};         send_number(5'd7);
    number_bytes = '{8'h5D};         send_number(5'd0);
    number_bytes = '{8'h1D};         send_number(5'd1);
    number_bytes = '{8'h12, 8'h3C};  send_number(5'd2);
    number_bytes = '{8'h00, 8'h1A};  send_number(5'd31);
    number_bytes = '{8'h10, 8'h0E};  send_number(5'd3);
    number_bytes = '{8'h45, 8'h6F};  send_number(5'd0);
    number_bytes = '{8'h12, 8'h39};  send_number(5'd1);
    number_bytes = '{8'hA0, 8'h05};  send_number(5'd0);
    number_bytes = '{8'h1F, 8'h2C};  send_number(5'd2);
    number_bytes = '{8'hF9, 8'h9B};  send_number(5'd16);

    // Random numbers across sender idle phases
    num_idx = 0;
    while (sent_bytes < BYTE_TARGET) begin
      idle_pct = phase_idle[(sent_bytes / 50) % 4];
      send_random_number(num_idx);
      num_idx++;
    end
    start <= 1'b0;

    // Drain, then give the back end time to show any stray result
    while (board.expected_text.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (board.errors == 0)
      $display("tb_packed_bcd_to_decimal_text OK");
    else
      $display("tb_packed_bcd_to_decimal_text NOT OK");
    $finish;
  end
endmodule

>>> sim.f
sv/pbdt_pkg.sv
sv/pbdt_ram.sv
sv/pbdt_front.sv
sv/pbdt_queue.sv
sv/pbdt_back.sv
sv/packed_bcd_to_decimal_text.sv
sim/tb_packed_bcd_to_decimal_text.sv
